### hw/rtl/tlkcd_pkg.sv
// Shared types and constants for the tagged LRU key cache directory.
package tlkcd_pkg;

  localparam int unsigned ENTRIES_DEF    = 8;
  localparam int unsigned SALT_BYTES_DEF = 16;
  localparam int unsigned IDX_W          = 6;
  localparam int unsigned STAMP_W        = 64;
  localparam int unsigned HASH_W         = 256;
  localparam int unsigned SALT_W         = 128;
  localparam int unsigned ROUND_W        = 32;

  typedef enum logic [1:0] {
    STATUS_HIT     = 2'd0,
    STATUS_MISS    = 2'd1,
    STATUS_REJECT  = 2'd2,
    STATUS_FLUSHED = 2'd3
  } status_e;

  typedef struct packed {
    logic               flush;
    logic [HASH_W-1:0]  hash;
    logic [SALT_W-1:0]  salt;
    logic [ROUND_W-1:0] rounds;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               inv;
    logic [IDX_W-1:0]   inv_idx;
    logic               have;
    logic [STAMP_W-1:0] best_stamp;
    logic [IDX_W-1:0]   best_idx;
  } acc_t;

  typedef struct packed {
    logic               flush;
    logic               install;
    logic               stamp_wr;
    logic [IDX_W-1:0]   sel;
    logic [STAMP_W-1:0] stamp;
  } upd_t;

endpackage

### hw/rtl/tlkcd_cell.sv
// One directory entry with its stage of the search and victim chain.
module tlkcd_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            active_i,
  input  tlkcd_pkg::req_t req_i,
  input  tlkcd_pkg::acc_t acc_i,
  input  tlkcd_pkg::upd_t upd_i,
  output tlkcd_pkg::acc_t acc_o
);
  import tlkcd_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic               valid_q, valid_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic [HASH_W-1:0]  hash_q;
  logic [SALT_W-1:0]  salt_q;
  logic [ROUND_W-1:0] rounds_q;
  acc_t               acc_q, acc_d;
  logic               match;
  logic               sel;

  assign match = valid_q && (rounds_q == req_i.rounds) && (hash_q == req_i.hash) &&
                 (salt_q == req_i.salt);
  assign sel   = (upd_i.sel == MY_IDX);

  always_comb begin
    acc_d = acc_i;
    if (active_i) begin
      if (!acc_i.hit && match) begin
        acc_d.hit     = 1'b1;
        acc_d.hit_idx = MY_IDX;
      end
      if (!acc_i.inv && !valid_q) begin
        acc_d.inv     = 1'b1;
        acc_d.inv_idx = MY_IDX;
      end
      if (!acc_i.have || (stamp_q < acc_i.best_stamp)) begin
        acc_d.have       = 1'b1;
        acc_d.best_stamp = stamp_q;
        acc_d.best_idx   = MY_IDX;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    stamp_d = stamp_q;
    if (upd_i.flush) begin
      valid_d = 1'b0;
      stamp_d = '0;
    end else begin
      if (upd_i.install && sel) valid_d = 1'b1;
      if (upd_i.stamp_wr && sel) stamp_d = upd_i.stamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      stamp_q <= '0;
    end else begin
      valid_q <= valid_d;
      stamp_q <= stamp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (!upd_i.flush && upd_i.install && sel) begin
      hash_q   <= req_i.hash;
      salt_q   <= req_i.salt;
      rounds_q <= req_i.rounds;
    end
  end

  assign acc_o = acc_q;

endmodule

### hw/rtl/tagged_lru_key_cache_directory_core.sv
// Top level of the tagged LRU key cache directory: request control and cell chain.
// Lookup: the result is registered once the search and victim accumulator has stepped one cell
// per cycle along the chain of ENTRIES cells; it waits in ST_FIN while an earlier result is stalled.
// Flush and zero-round requests skip the scan; their result is registered from ST_FIN.
// A new request is taken only in ST_IDLE, after the previous result has been registered.
// Reset: all entries invalid, use stamps zero, stamp counter one, active_slots eight.
module tagged_lru_key_cache_directory_core #(
  parameter int unsigned ENTRIES    = tlkcd_pkg::ENTRIES_DEF,
  parameter int unsigned SALT_BYTES = tlkcd_pkg::SALT_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [63:0] hash_word0_i,
  input  logic [63:0] hash_word1_i,
  input  logic [63:0] hash_word2_i,
  input  logic [63:0] hash_word3_i,
  input  logic [63:0] salt_word0_i,
  input  logic [63:0] salt_word1_i,
  input  logic [31:0] round_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [2:0]  slot_o
);
  import tlkcd_pkg::*;

  localparam int unsigned CW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);
  localparam logic [SALT_W-1:0] SALT_MASK = {SALT_W{1'b1}} >> (SALT_W - 8 * SALT_BYTES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [3:0]         cfg_q;
  logic [STAMP_W-1:0] ctr_q, ctr_d;
  req_t               req_q;
  logic               reject_q;
  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic [2:0]         slot_q, slot_d;
  logic               in_acc;
  logic               fin_go;
  logic [ENTRIES-1:0] active;
  acc_t               chain [ENTRIES+1];
  acc_t               acc_last;
  upd_t               upd;
  logic [IDX_W-1:0]   chosen;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign fin_go      = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  assign chain[0] = '0;
  assign acc_last = chain[ENTRIES];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    assign active[k] = (k == 0) || ({3'b000, cfg_q} > 7'(k));
    tlkcd_cell #(.INDEX(k)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (active[k]),
      .req_i    (req_q),
      .acc_i    (chain[k]),
      .upd_i    (upd),
      .acc_o    (chain[k+1])
    );
  end

  always_comb begin
    if (acc_last.hit)      chosen = acc_last.hit_idx;
    else if (acc_last.inv) chosen = acc_last.inv_idx;
    else                   chosen = acc_last.best_idx;
  end

  always_comb begin
    upd          = '0;
    upd.sel      = chosen;
    upd.stamp    = ctr_q;
    ctr_d        = ctr_q;
    status_d     = status_q;
    slot_d       = slot_q;
    out_valid_d  = out_valid_q && out_stall_i;
    if (fin_go) begin
      out_valid_d = 1'b1;
      if (req_q.flush) begin
        upd.flush = 1'b1;
        ctr_d     = STAMP_W'(1);
        status_d  = STATUS_FLUSHED;
        slot_d    = '0;
      end else if (reject_q) begin
        status_d = STATUS_REJECT;
        slot_d   = '0;
      end else begin
        upd.install  = !acc_last.hit;
        upd.stamp_wr = 1'b1;
        ctr_d        = ctr_q + STAMP_W'(1);
        status_d     = acc_last.hit ? STATUS_HIT : STATUS_MISS;
        slot_d       = chosen[2:0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d   = '0;
          state_d = (cmd_i || (round_count_i == '0)) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == LAST) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cfg_q       <= 4'd8;
      ctr_q       <= STAMP_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    slot_q   <= slot_d;
    if (in_acc) begin
      req_q.flush  <= cmd_i;
      req_q.hash   <= {hash_word3_i, hash_word2_i, hash_word1_i, hash_word0_i};
      req_q.salt   <= {salt_word1_i, salt_word0_i} & SALT_MASK;
      req_q.rounds <= round_count_i;
      reject_q     <= !cmd_i && (round_count_i == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;

`ifndef SYNTH
  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_o)
    else $error("finished request not presented");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SCAN || state_q == ST_FIN))
    else $error("accepted request did not start");
  a_flush_ctr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && req_q.flush) |=> (ctr_q == STAMP_W'(1)))
    else $error("stamp counter not restored by flush");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= LAST))
    else $error("scan counter out of range");
`endif

endmodule

### tb/tagged_lru_key_cache_directory_core_tb.sv
// Self-checking testbench for the tagged LRU key cache directory core.
`timescale 1ns / 1ps

module tagged_lru_key_cache_directory_core_tb;
  import tlkcd_pkg::*;

  localparam int unsigned NSLOTS      = ENTRIES_DEF;
  localparam int unsigned POOL_SIZE   = 12;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 106;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [SALT_W-1:0] SALT_MASK = (SALT_BYTES_DEF >= 16) ? {SALT_W{1'b1}} :
                                            ((128'd1 << (8 * SALT_BYTES_DEF)) - 128'd1);
  localparam logic [3:0] PHASE_SLOTS [PHASES] = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd4,
                                                  4'd8, 4'd9, 4'd2, 4'd6, 4'd7};

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [SALT_W-1:0]  salt;
    logic [ROUND_W-1:0] rounds;
  } key_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        cmd_i;
  logic [63:0] hash_word0_i;
  logic [63:0] hash_word1_i;
  logic [63:0] hash_word2_i;
  logic [63:0] hash_word3_i;
  logic [63:0] salt_word0_i;
  logic [63:0] salt_word1_i;
  logic [31:0] round_count_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [2:0]  slot_o;

  logic              dir_valid [NSLOTS];
  key_t              dir_key   [NSLOTS];
  logic [63:0]       dir_stamp [NSLOTS];
  logic [63:0]       stamp_ctr;
  logic [3:0]        active_cfg;

  outcome_t          pending_results [$];
  key_t              key_pool [POOL_SIZE];
  key_t              lru_keys [5];
  int unsigned       error_count;
  int unsigned       cycle_count;
  int unsigned       hold_off_cycles;
  int unsigned       stall_left;
  logic              send_idle;
  logic              recv_idle;

  tagged_lru_key_cache_directory_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .hash_word0_i (hash_word0_i),
    .hash_word1_i (hash_word1_i),
    .hash_word2_i (hash_word2_i),
    .hash_word3_i (hash_word3_i),
    .salt_word0_i (salt_word0_i),
    .salt_word1_i (salt_word1_i),
    .round_count_i(round_count_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .slot_o       (slot_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void clear_directory();
    for (int s = 0; s < NSLOTS; s++) begin
      dir_valid[s] = 1'b0;
      dir_key[s]   = '0;
      dir_stamp[s] = '0;
    end
    stamp_ctr = 64'd1;
  endfunction

  function automatic outcome_t predict_directory(input logic cmd, input key_t key);
    outcome_t    res;
    int unsigned n;
    int unsigned chosen;
    logic        found;
    logic        picked;
    logic [63:0] oldest;
    res.slot = '0;
    if (cmd) begin
      clear_directory();
      res.status = STATUS_FLUSHED;
      return res;
    end
    if (key.rounds == '0) begin
      res.status = STATUS_REJECT;
      return res;
    end
    key.salt = key.salt & SALT_MASK;
    n = (active_cfg == 4'd0) ? 1 : ((active_cfg > NSLOTS) ? NSLOTS : active_cfg);
    found  = 1'b0;
    chosen = 0;
    for (int s = 0; s < n; s++) begin
      if (!found && dir_valid[s] && dir_key[s] == key) begin
        found  = 1'b1;
        chosen = s;
      end
    end
    if (!found) begin
      picked = 1'b0;
      for (int s = 0; s < n; s++) begin
        if (!picked && !dir_valid[s]) begin
          picked = 1'b1;
          chosen = s;
        end
      end
      if (!picked) begin
        chosen = 0;
        oldest = dir_stamp[0];
        for (int s = 1; s < n; s++) begin
          if (dir_stamp[s] < oldest) begin
            oldest = dir_stamp[s];
            chosen = s;
          end
        end
      end
      dir_key[chosen]   = key;
      dir_valid[chosen] = 1'b1;
    end
    dir_stamp[chosen] = stamp_ctr;
    stamp_ctr         = stamp_ctr + 64'd1;
    res.status = found ? STATUS_HIT : STATUS_MISS;
    res.slot   = chosen[2:0];
    return res;
  endfunction

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic key_t random_key();
    key_t key;
    key.hash   = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom};
    key.salt   = {$urandom, $urandom, $urandom, $urandom};
    key.rounds = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom;
    return key;
  endfunction

  function automatic key_t near_key(input key_t key);
    case ($urandom_range(0, 2))
      0:       key.hash   = key.hash ^ (256'd1 << $urandom_range(0, HASH_W - 1));
      1:       key.salt   = key.salt ^ (128'd1 << $urandom_range(0, SALT_W - 1));
      default: key.rounds = key.rounds ^ (32'd1 << $urandom_range(0, ROUND_W - 1));
    endcase
    return key;
  endfunction

  task automatic send_request(input logic cmd, input key_t key);
    int unsigned gap;
    gap = send_idle ? idle_length() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    hash_word0_i  <= key.hash[63:0];
    hash_word1_i  <= key.hash[127:64];
    hash_word2_i  <= key.hash[191:128];
    hash_word3_i  <= key.hash[255:192];
    salt_word0_i  <= key.salt[63:0];
    salt_word1_i  <= key.salt[127:64];
    round_count_i <= key.rounds;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_directory(cmd, key));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (NSLOTS + 4) @(posedge clk_i);
  endtask

  task automatic write_active_slots(input logic [3:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    active_cfg   = value;
    cfg_valid_i <= 1'b0;
  endtask

  // hold the output side while stalled, with long stretches on request
  initial begin
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        hold_off_cycles = hold_off_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        if (stall_left == 0 && recv_idle && $urandom_range(0, 3) == 0)
          stall_left = idle_length();
        if (stall_left > 0) begin
          stall_left = stall_left - 1;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d slot %0d", $time, status_o, slot_o);
        error_count++;
      end else begin
        if (status_o !== pending_results[0].status) begin
          $display("%0t: status expected %0d got %0d", $time,
                   pending_results[0].status, status_o);
          error_count++;
        end
        if (slot_o !== pending_results[0].slot) begin
          $display("%0t: slot expected %0d got %0d", $time, pending_results[0].slot, slot_o);
          error_count++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic test_empty_directory();
    key_t key;
    key = '1;
    send_request(1'b0, key);
    send_request(1'b0, key);
    key = '0;
    send_request(1'b0, key);
    key.rounds = 32'd1;
    send_request(1'b0, key);
    send_request(1'b1, '0);
    send_request(1'b0, '1);
  endtask

  task automatic test_partial_match();
    key_t base;
    key_t variant;
    base = random_key();
    base.rounds = 32'd1000;
    send_request(1'b0, base);
    variant = base;
    variant.hash[HASH_W-1] = ~variant.hash[HASH_W-1];
    send_request(1'b0, variant);
    variant = base;
    variant.salt[SALT_W-1] = ~variant.salt[SALT_W-1];
    send_request(1'b0, variant);
    variant = base;
    variant.rounds = base.rounds + 32'd1;
    send_request(1'b0, variant);
    send_request(1'b0, base);
  endtask

  task automatic test_lru_eviction();
    for (int i = 0; i < 5; i++) lru_keys[i] = random_key();
    send_request(1'b1, random_key());
    write_active_slots(4'd4);
    for (int i = 0; i < 4; i++) send_request(1'b0, lru_keys[i]);
    send_request(1'b0, lru_keys[0]);
    send_request(1'b0, lru_keys[4]);
    send_request(1'b0, lru_keys[1]);
  endtask

  task automatic test_inactive_slots();
    key_t fresh;
    fresh = random_key();
    write_active_slots(4'd2);
    send_request(1'b0, fresh);
    write_active_slots(4'd8);
    send_request(1'b0, lru_keys[3]);
    write_active_slots(4'd0);
    send_request(1'b0, fresh);
    send_request(1'b0, fresh);
    write_active_slots(4'd15);
    send_request(1'b0, lru_keys[3]);
  endtask

  task automatic test_flush_precedence();
    key_t key;
    key = '1;
    key.rounds = '0;
    send_request(1'b1, key);
    send_request(1'b0, '1);
  endtask

  task automatic send_random_request();
    key_t        key;
    int unsigned pick;
    int unsigned r;
    pick = $urandom_range(0, POOL_SIZE - 1);
    key  = key_pool[pick];
    r    = $urandom_range(0, 99);
    if (r < 2) begin
      send_request(1'b1, random_key());
    end else if (r < 5) begin
      key.rounds = '0;
      send_request(1'b0, key);
    end else if (r < 70) begin
      send_request(1'b0, key);
    end else if (r < 82) begin
      send_request(1'b0, near_key(key));
    end else begin
      key_pool[pick] = random_key();
      send_request(1'b0, key_pool[pick]);
    end
  endtask

  task automatic test_backpressure();
    settle();
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = random_key();
    send_idle = 1'b0;
    hold_off_cycles = 300;
    for (int i = 0; i < 40; i++) send_random_request();
    send_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < PHASES; phase++) begin
      write_active_slots(PHASE_SLOTS[phase]);
      send_idle = (phase % 3) != 1 && phase != 4;
      recv_idle = (phase % 3) != 2 && phase != 4;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_request();
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    error_count     = 0;
    hold_off_cycles = 0;
    send_idle       = 1'b1;
    recv_idle       = 1'b1;
    active_cfg      = 4'd8;
    clear_directory();
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    cmd_i         <= 1'b0;
    hash_word0_i  <= '0;
    hash_word1_i  <= '0;
    hash_word2_i  <= '0;
    hash_word3_i  <= '0;
    salt_word0_i  <= '0;
    salt_word1_i  <= '0;
    round_count_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_directory();
    test_partial_match();
    test_lru_eviction();
    test_inactive_slots();
    test_flush_precedence();
    test_backpressure();
    test_random_traffic();
    settle();
    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
